[rtl/ring_slot_ownership_tracker_macros.svh]
// Assertion macros for the ring slot ownership tracker.
// Used by the top level only; no other dependencies.
`ifndef RING_SLOT_OWNERSHIP_TRACKER_MACROS_SVH
`define RING_SLOT_OWNERSHIP_TRACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define RSOT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rsot assertion failed");

// Next-cycle implication, disabled while reset is low.
`define RSOT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rsot assertion failed");

`endif

[rtl/rsot_pkg.sv]
// Package for the ring slot ownership tracker: constants, codes, types, helpers.
// No dependencies.
package rsot_pkg;

    localparam int FRAMES_PER_MSG = 8;
    localparam int SEQ_BITS       = 48;
    localparam int MAX_SLOTS      = 4096;

    localparam int SLOT_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
    localparam int NUM_IDX    = 4;

    localparam int CMD_W      = 3;
    localparam int FRAME_W    = 18;
    localparam int BYTES_W    = 32;
    localparam int STATUS_W   = 3;
    localparam int RPF_W      = 19;
    localparam int SLOTCFG_W  = 13;
    localparam int FBYTES_W   = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BYTES = 2'd1;

    localparam logic [SLOTCFG_W-1:0] SLOT_COUNT_RST  = 13'd16;
    localparam logic [FBYTES_W-1:0]  FRAME_BYTES_RST = 17'd4096;

    localparam int IX_TXA = 0;
    localparam int IX_TXS = 1;
    localparam int IX_TXD = 2;
    localparam int IX_RXA = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACQUIRE_TX  = 3'd0,
        CMD_SUBMIT_TX   = 3'd1,
        CMD_RX_CONSUMED = 3'd2,
        CMD_RX_EVENT    = 3'd3,
        CMD_TX_DONE     = 3'd4,
        CMD_CLOSE       = 3'd5,
        CMD_QUIESCE     = 3'd6
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_RETRY       = 3'd1,
        ST_ORDER       = 3'd2,
        ST_GEOMETRY    = 3'd3,
        ST_PEER_GONE   = 3'd4,
        ST_ACCOUNTING  = 3'd5,
        ST_OUTSTANDING = 3'd6
    } status_t;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [SEQ_BITS-1:0] seq;
        logic [FRAME_W-1:0]  first;
        logic [FRAME_W-1:0]  nframes;
        logic [BYTES_W-1:0]  byte_count;
    } item_t;

    typedef struct packed {
        logic [SEQ_BITS-1:0]              txa;
        logic [SEQ_BITS-1:0]              txs;
        logic [SEQ_BITS-1:0]              txd;
        logic [SEQ_BITS-1:0]              rxa;
        logic [SEQ_BITS-1:0]              rxc;
        logic [SEQ_BITS-1:0]              rxr;
        logic [NUM_IDX-1:0][SLOT_W-1:0]   idx;
        logic                             peer_gone;
    } state_t;

    typedef struct packed {
        status_t             status;
        logic [RPF_W-1:0]    repost_frames;
        logic [FRAME_W-1:0]  slot_first_frame;
        logic                closed_flag;
        logic                all_idle;
    } result_t;

    function automatic logic [SLOT_W-1:0] next_index(input logic [SLOT_W-1:0] idx,
                                                     input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] nxt;
        nxt = CNT_W'(idx) + CNT_W'(1);
        return (nxt >= n) ? '0 : nxt[SLOT_W-1:0];
    endfunction

    function automatic logic [FRAME_W-1:0] first_frame(input logic [SLOT_W-1:0] idx);
        return FRAME_W'(idx) * FRAME_W'(FRAMES_PER_MSG);
    endfunction

endpackage

[rtl/rsot_repost.sv]
// Receive repost accounting: ready point, fault check and frame count.
// Depends on rsot_pkg.
module rsot_repost (
    input  logic [rsot_pkg::SEQ_BITS-1:0] arrived,
    input  logic [rsot_pkg::SEQ_BITS-1:0] consumed,
    input  logic [rsot_pkg::SEQ_BITS-1:0] reposted,
    input  logic [rsot_pkg::CNT_W-1:0]    slots,
    output logic                          ok,
    output logic [rsot_pkg::SEQ_BITS-1:0] reposted_next,
    output logic [rsot_pkg::RPF_W-1:0]    frames
);
    import rsot_pkg::*;

    logic [SEQ_BITS-1:0] through;
    logic [SEQ_BITS-1:0] ready;

    assign through       = (arrived < consumed) ? arrived : consumed;
    assign ready         = through - reposted;
    assign ok            = (through >= reposted) && (ready <= SEQ_BITS'(slots));
    assign reposted_next = ok ? through : reposted;
    assign frames        = ok ? RPF_W'(ready[CNT_W-1:0]) * RPF_W'(FRAMES_PER_MSG) : '0;

endmodule

[rtl/rsot_step.sv]
// One item's checks and counter updates: current state and item in,
// next state and result out. Depends on rsot_pkg and rsot_repost.
module rsot_step (
    input  rsot_pkg::item_t                 item,
    input  rsot_pkg::state_t                cur,
    input  logic [rsot_pkg::SLOTCFG_W-1:0]  slot_count,
    input  logic [rsot_pkg::FBYTES_W-1:0]   frame_bytes,
    output rsot_pkg::state_t                nxt,
    output rsot_pkg::result_t               res
);
    import rsot_pkg::*;

    cmd_t                cmd;
    logic [CNT_W-1:0]    n;
    logic [SEQ_BITS-1:0] seq_minus_n;
    logic                acq_free;
    logic                geom_ok;
    logic                rx_ev_ok;
    logic                tx_ev_ok;
    logic                cons_ok;
    logic [SEQ_BITS-1:0] rp_a;
    logic [SEQ_BITS-1:0] rp_c;
    logic                rp_ok;
    logic [SEQ_BITS-1:0] rp_r_next;
    logic [RPF_W-1:0]    rp_frames;
    logic                idle_after_repost;

    assign cmd = cmd_t'(item.cmd);

    always_comb begin
        if (slot_count == '0) begin
            n = CNT_W'(1);
        end else if (32'(slot_count) > 32'(MAX_SLOTS)) begin
            n = CNT_W'(MAX_SLOTS);
        end else begin
            n = CNT_W'(slot_count);
        end
    end

    assign seq_minus_n = item.seq - SEQ_BITS'(n);
    assign acq_free    = (item.seq < SEQ_BITS'(n)) || (cur.txd > seq_minus_n);
    assign geom_ok     = (item.nframes == FRAME_W'(FRAMES_PER_MSG));
    assign rx_ev_ok    = (item.first == first_frame(cur.idx[IX_RXA])) && geom_ok &&
                         (item.byte_count == BYTES_W'(FRAMES_PER_MSG) * BYTES_W'(frame_bytes));
    assign tx_ev_ok    = (cur.txd < cur.txs) && (item.first == first_frame(cur.idx[IX_TXD])) &&
                         geom_ok && (item.byte_count == '0);
    assign cons_ok     = (item.seq == cur.rxc);

    assign rp_a = (cmd == CMD_RX_EVENT && rx_ev_ok) ? cur.rxa + SEQ_BITS'(1) : cur.rxa;
    assign rp_c = (cmd == CMD_RX_CONSUMED && cons_ok) ? cur.rxc + SEQ_BITS'(1) : cur.rxc;

    rsot_repost u_repost (
        .arrived       (rp_a),
        .consumed      (rp_c),
        .reposted      (cur.rxr),
        .slots         (n),
        .ok            (rp_ok),
        .reposted_next (rp_r_next),
        .frames        (rp_frames)
    );

    assign idle_after_repost = (cur.txa == cur.txs) && (cur.txd == cur.txs) &&
                               (cur.rxa == cur.rxc) && (cur.rxc == rp_r_next);

    always_comb begin
        nxt                  = cur;
        res.status           = ST_OK;
        res.repost_frames    = '0;
        res.slot_first_frame = '0;
        unique case (cmd)
            CMD_ACQUIRE_TX: begin
                if (item.seq != cur.txa) begin
                    res.status = ST_ORDER;
                end else if (cur.peer_gone) begin
                    res.status = ST_PEER_GONE;
                end else if (!acq_free) begin
                    res.status = ST_RETRY;
                end else begin
                    res.slot_first_frame = first_frame(cur.idx[IX_TXA]);
                    nxt.txa              = cur.txa + SEQ_BITS'(1);
                    nxt.idx[IX_TXA]      = next_index(cur.idx[IX_TXA], n);
                end
            end
            CMD_SUBMIT_TX: begin
                if (item.seq != cur.txs || item.seq >= cur.txa) begin
                    res.status = ST_ORDER;
                end else if (cur.peer_gone) begin
                    res.status = ST_PEER_GONE;
                end else if (item.first != first_frame(cur.idx[IX_TXS])) begin
                    res.status = ST_GEOMETRY;
                end else begin
                    nxt.txs         = cur.txs + SEQ_BITS'(1);
                    nxt.idx[IX_TXS] = next_index(cur.idx[IX_TXS], n);
                end
            end
            CMD_RX_CONSUMED: begin
                if (!cons_ok) begin
                    res.status = ST_ORDER;
                end else begin
                    nxt.rxc           = rp_c;
                    nxt.rxr           = rp_r_next;
                    res.repost_frames = rp_frames;
                    if (!rp_ok) begin
                        res.status = ST_ACCOUNTING;
                    end else if (rp_r_next > item.seq) begin
                        res.status = ST_OK;
                    end else if (cur.peer_gone) begin
                        res.status = ST_PEER_GONE;
                    end else begin
                        res.status = ST_RETRY;
                    end
                end
            end
            CMD_RX_EVENT: begin
                if (!rx_ev_ok) begin
                    res.status = ST_GEOMETRY;
                end else begin
                    nxt.rxa           = rp_a;
                    nxt.idx[IX_RXA]   = next_index(cur.idx[IX_RXA], n);
                    nxt.rxr           = rp_r_next;
                    res.repost_frames = rp_frames;
                    if (!rp_ok) begin
                        res.status = ST_ACCOUNTING;
                    end
                end
            end
            CMD_TX_DONE: begin
                if (!tx_ev_ok) begin
                    res.status = ST_GEOMETRY;
                end else begin
                    nxt.txd           = cur.txd + SEQ_BITS'(1);
                    nxt.idx[IX_TXD]   = next_index(cur.idx[IX_TXD], n);
                    nxt.rxr           = rp_r_next;
                    res.repost_frames = rp_frames;
                    if (!rp_ok) begin
                        res.status = ST_ACCOUNTING;
                    end
                end
            end
            CMD_CLOSE: begin
                nxt.peer_gone     = 1'b1;
                nxt.rxr           = rp_r_next;
                res.repost_frames = rp_frames;
                if (!rp_ok) begin
                    res.status = ST_ACCOUNTING;
                end
            end
            CMD_QUIESCE: begin
                nxt.rxr           = rp_r_next;
                res.repost_frames = rp_frames;
                if (!rp_ok) begin
                    res.status = ST_ACCOUNTING;
                end else if (idle_after_repost) begin
                    res.status = ST_OK;
                end else if (cur.peer_gone) begin
                    res.status = ST_OUTSTANDING;
                end else begin
                    res.status = ST_RETRY;
                end
            end
            default: begin
                res.status = ST_GEOMETRY;
            end
        endcase
        res.closed_flag = nxt.peer_gone;
        res.all_idle    = (nxt.txa == nxt.txs) && (nxt.txd == nxt.txs) &&
                          (nxt.rxa == nxt.rxc) && (nxt.rxc == nxt.rxr);
    end

endmodule

[rtl/ring_slot_ownership_tracker.sv]
// An accepted input beat reaches its result beat through the input register, then the
// result register; throughput one item per cycle while the result side takes beats.
// Counters, slot indices and the peer-closed flag update as an item moves into the
// result register. Reset clears all counters, indices and flags, empties both
// registers and loads slot_count 16 and frame_bytes 4096. No clearing pass.
// Depends on rsot_pkg, rsot_step and ring_slot_ownership_tracker_macros.svh.
module ring_slot_ownership_tracker (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rsot_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rsot_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [rsot_pkg::CMD_W-1:0]       s_cmd,
    input  logic [rsot_pkg::SEQ_BITS-1:0]    s_seq,
    input  logic [rsot_pkg::FRAME_W-1:0]     s_first,
    input  logic [rsot_pkg::FRAME_W-1:0]     s_nframes,
    input  logic [rsot_pkg::BYTES_W-1:0]     s_byte_count,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [rsot_pkg::STATUS_W-1:0]    m_status,
    output logic [rsot_pkg::RPF_W-1:0]       m_repost_frames,
    output logic [rsot_pkg::FRAME_W-1:0]     m_slot_first_frame,
    output logic                             m_closed_flag,
    output logic                             m_all_idle
);
    import rsot_pkg::*;

    `include "ring_slot_ownership_tracker_macros.svh"

    logic                   in_valid_reg;
    item_t                  in_item_reg;
    logic                   out_valid_reg;
    result_t                out_res_reg;
    state_t                 state_reg;
    state_t                 state_next;
    result_t                res_next;
    logic [SLOTCFG_W-1:0]   slot_count_reg;
    logic [FBYTES_W-1:0]    frame_bytes_reg;
    logic                   advance;
    item_t                  s_item;

    assign s_item.cmd        = s_cmd;
    assign s_item.seq        = s_seq;
    assign s_item.first      = s_first;
    assign s_item.nframes    = s_nframes;
    assign s_item.byte_count = s_byte_count;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    rsot_step u_step (
        .item        (in_item_reg),
        .cur         (state_reg),
        .slot_count  (slot_count_reg),
        .frame_bytes (frame_bytes_reg),
        .nxt         (state_next),
        .res         (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg       <= '0;
            slot_count_reg  <= SLOT_COUNT_RST;
            frame_bytes_reg <= FRAME_BYTES_RST;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_SLOT_COUNT:  slot_count_reg  <= cfg_data[SLOTCFG_W-1:0];
                    CFG_FRAME_BYTES: frame_bytes_reg <= cfg_data[FBYTES_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_status           = out_res_reg.status;
    assign m_repost_frames    = out_res_reg.repost_frames;
    assign m_slot_first_frame = out_res_reg.slot_first_frame;
    assign m_closed_flag      = out_res_reg.closed_flag;
    assign m_all_idle         = out_res_reg.all_idle;

    `RSOT_ASSERT_NEXT(a_peer_sticky, aclk, aresetn, state_reg.peer_gone, state_reg.peer_gone)
    `RSOT_ASSERT_NEXT(a_stall_holds_state, aclk, aresetn, !advance, $stable(state_reg))
    `RSOT_ASSERT_NOW(a_grant_only_on_ok, aclk, aresetn, advance && res_next.status != ST_OK, res_next.slot_first_frame == '0)
    `RSOT_ASSERT_NOW(a_closed_matches_state, aclk, aresetn, advance, res_next.closed_flag == state_next.peer_gone)

endmodule

[bench/tb_top.sv]
// Self-checking bench for ring_slot_ownership_tracker: directed command streams, then
// random traffic over several slot and frame size settings, checked beat by beat.
// Depends on rsot_pkg and the tracker RTL; the expected results come from an in-bench model.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rsot_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
    localparam int STALL_LIMIT = 4000;
    localparam int REPORT_MAX  = 10;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_cmd;
    logic [SEQ_BITS-1:0]   s_seq;
    logic [FRAME_W-1:0]    s_first;
    logic [FRAME_W-1:0]    s_nframes;
    logic [BYTES_W-1:0]    s_byte_count;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [STATUS_W-1:0]   m_status;
    logic [RPF_W-1:0]      m_repost_frames;
    logic [FRAME_W-1:0]    m_slot_first_frame;
    logic                  m_closed_flag;
    logic                  m_all_idle;

    logic [SEQ_BITS-1:0]   tx_acq, tx_sub, tx_done, rx_arr, rx_con, rx_rep;
    logic [SLOT_W-1:0]     slot_ix [NUM_IDX];
    logic                  link_gone;
    logic [SLOTCFG_W-1:0]  reg_slots;
    logic [FBYTES_W-1:0]   reg_fbytes;

    result_t               pending_status [$];
    result_t               due;
    int                    mismatches = 0;
    int                    quiet_cycles = 0;
    int                    stall_left = 0;
    bit                    calm = 1'b0;

    ring_slot_ownership_tracker dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_cmd              (s_cmd),
        .s_seq              (s_seq),
        .s_first            (s_first),
        .s_nframes          (s_nframes),
        .s_byte_count       (s_byte_count),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_repost_frames    (m_repost_frames),
        .m_slot_first_frame (m_slot_first_frame),
        .m_closed_flag      (m_closed_flag),
        .m_all_idle         (m_all_idle)
    );

    always #1 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CNT_W-1:0] live_slots();
        if (reg_slots == '0) return CNT_W'(1);
        if (reg_slots > MAX_SLOTS) return CNT_W'(MAX_SLOTS);
        return reg_slots;
    endfunction

    function automatic logic [FRAME_W-1:0] slot_base(input int k);
        return FRAME_W'(slot_ix[k]) * FRAME_W'(FRAMES_PER_MSG);
    endfunction

    function automatic void bump_slot(input int k);
        logic [CNT_W-1:0] nxt;
        nxt = CNT_W'(slot_ix[k]) + CNT_W'(1);
        slot_ix[k] = (nxt >= live_slots()) ? '0 : nxt[SLOT_W-1:0];
    endfunction

    function automatic bit reclaim_rx(output logic [RPF_W-1:0] frames);
        logic [SEQ_BITS-1:0] through;
        logic [SEQ_BITS-1:0] ready;
        frames = '0;
        through = (rx_arr < rx_con) ? rx_arr : rx_con;
        if (through < rx_rep) return 1'b0;
        ready = through - rx_rep;
        if (ready > live_slots()) return 1'b0;
        rx_rep = rx_rep + ready;
        frames = RPF_W'(ready * FRAMES_PER_MSG);
        return 1'b1;
    endfunction

    function automatic bit ring_idle();
        return tx_acq == tx_sub && tx_done == tx_sub && rx_arr == rx_con && rx_con == rx_rep;
    endfunction

    function automatic void predict_ring_status(input item_t it);
        result_t          r;
        logic [CNT_W-1:0] n;
        logic [RPF_W-1:0] frames;
        n = live_slots();
        r = '0;
        frames = '0;
        r.status = ST_OK;
        case (it.cmd)
            CMD_ACQUIRE_TX: begin
                if (it.seq != tx_acq) r.status = ST_ORDER;
                else if (link_gone) r.status = ST_PEER_GONE;
                else if (!(it.seq < n || tx_done > it.seq - n)) r.status = ST_RETRY;
                else begin
                    r.slot_first_frame = slot_base(IX_TXA);
                    tx_acq = tx_acq + 1'b1;
                    bump_slot(IX_TXA);
                end
            end
            CMD_SUBMIT_TX: begin
                if (it.seq != tx_sub || it.seq >= tx_acq) r.status = ST_ORDER;
                else if (link_gone) r.status = ST_PEER_GONE;
                else if (it.first != slot_base(IX_TXS)) r.status = ST_GEOMETRY;
                else begin
                    tx_sub = tx_sub + 1'b1;
                    bump_slot(IX_TXS);
                end
            end
            CMD_RX_CONSUMED: begin
                if (it.seq != rx_con) r.status = ST_ORDER;
                else begin
                    rx_con = rx_con + 1'b1;
                    if (!reclaim_rx(frames)) r.status = ST_ACCOUNTING;
                    else if (rx_rep > it.seq) r.status = ST_OK;
                    else if (link_gone) r.status = ST_PEER_GONE;
                    else r.status = ST_RETRY;
                end
            end
            CMD_RX_EVENT: begin
                if (it.first != slot_base(IX_RXA) || it.nframes != FRAME_W'(FRAMES_PER_MSG) ||
                    64'(it.byte_count) != 64'(FRAMES_PER_MSG) * 64'(reg_fbytes)) begin
                    r.status = ST_GEOMETRY;
                end else begin
                    rx_arr = rx_arr + 1'b1;
                    bump_slot(IX_RXA);
                    if (!reclaim_rx(frames)) r.status = ST_ACCOUNTING;
                end
            end
            CMD_TX_DONE: begin
                if (tx_done >= tx_sub || it.first != slot_base(IX_TXD) ||
                    it.nframes != FRAME_W'(FRAMES_PER_MSG) || it.byte_count != '0) begin
                    r.status = ST_GEOMETRY;
                end else begin
                    tx_done = tx_done + 1'b1;
                    bump_slot(IX_TXD);
                    if (!reclaim_rx(frames)) r.status = ST_ACCOUNTING;
                end
            end
            CMD_CLOSE: begin
                link_gone = 1'b1;
                if (!reclaim_rx(frames)) r.status = ST_ACCOUNTING;
            end
            CMD_QUIESCE: begin
                if (!reclaim_rx(frames)) r.status = ST_ACCOUNTING;
                else if (ring_idle()) r.status = ST_OK;
                else if (link_gone) r.status = ST_OUTSTANDING;
                else r.status = ST_RETRY;
            end
            default: r.status = ST_GEOMETRY;
        endcase
        r.repost_frames = frames;
        r.closed_flag   = link_gone;
        r.all_idle      = ring_idle();
        pending_status.push_back(r);
    endfunction

    function automatic item_t ring_item(input logic [CMD_W-1:0] c, input logic [SEQ_BITS-1:0] s,
                                        input logic [FRAME_W-1:0] f, input logic [FRAME_W-1:0] n,
                                        input logic [BYTES_W-1:0] b);
        item_t it;
        it.cmd        = c;
        it.seq        = s;
        it.first      = f;
        it.nframes    = n;
        it.byte_count = b;
        return it;
    endfunction

    function automatic item_t noise_item();
        logic [CMD_W-1:0] c;
        c = CMD_W'($urandom_range(0, 6));
        if (c == CMD_CLOSE) c = CMD_UNUSED;
        return ring_item(c, SEQ_BITS'({$urandom, $urandom}), FRAME_W'($urandom),
                         FRAME_W'($urandom), $urandom);
    endfunction

    function automatic item_t well_formed(input cmd_t c);
        item_t it;
        it = noise_item();
        it.cmd = c;
        case (c)
            CMD_ACQUIRE_TX: it.seq = tx_acq;
            CMD_SUBMIT_TX: begin
                it.seq   = tx_sub;
                it.first = slot_base(IX_TXS);
            end
            CMD_RX_CONSUMED: it.seq = rx_con;
            CMD_RX_EVENT: begin
                it.first      = slot_base(IX_RXA);
                it.nframes    = FRAME_W'(FRAMES_PER_MSG);
                it.byte_count = BYTES_W'(FRAMES_PER_MSG * reg_fbytes);
            end
            CMD_TX_DONE: begin
                it.first      = slot_base(IX_TXD);
                it.nframes    = FRAME_W'(FRAMES_PER_MSG);
                it.byte_count = '0;
            end
            default: ;
        endcase
        return it;
    endfunction

    function automatic item_t broken(input cmd_t c);
        item_t it;
        it = well_formed(c);
        case ($urandom_range(0, 3))
            0: it.seq = it.seq ^ (SEQ_BITS'(1) << $urandom_range(0, SEQ_BITS - 1));
            1: it.first = it.first ^ (FRAME_W'(1) << $urandom_range(0, FRAME_W - 1));
            2: it.nframes = it.nframes ^ (FRAME_W'(1) << $urandom_range(0, FRAME_W - 1));
            default: it.byte_count = it.byte_count ^ (BYTES_W'(1) << $urandom_range(0, 31));
        endcase
        return it;
    endfunction

    task automatic send_ring_item(input item_t it);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= it.cmd;
        s_seq        <= it.seq;
        s_first      <= it.first;
        s_nframes    <= it.nframes;
        s_byte_count <= it.byte_count;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_ring_status(it);
    endtask

    task automatic settle_pipeline();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_tracker_reg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_SLOT_COUNT) reg_slots = val[SLOTCFG_W-1:0];
        else if (idx == CFG_FRAME_BYTES) reg_fbytes = val[FBYTES_W-1:0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_ring_traffic(input int count);
        int   pick;
        cmd_t c;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 20) c = CMD_ACQUIRE_TX;
            else if (pick < 38) c = CMD_SUBMIT_TX;
            else if (pick < 56) c = CMD_TX_DONE;
            else if (pick < 74) c = CMD_RX_EVENT;
            else if (pick < 92) c = CMD_RX_CONSUMED;
            else c = CMD_QUIESCE;
            pick = $urandom_range(0, 99);
            if (pick < 84) send_ring_item(well_formed(c));
            else if (pick < 94) send_ring_item(broken(c));
            else send_ring_item(noise_item());
        end
        calm = 1'b0;
    endtask

    task automatic test_directed_basics();
        item_t it;
        send_ring_item(well_formed(CMD_QUIESCE));
        send_ring_item(ring_item(CMD_UNUSED, '1, '1, '1, '1));
        send_ring_item(ring_item(CMD_ACQUIRE_TX, '1, '0, '0, '0));
        send_ring_item(well_formed(CMD_ACQUIRE_TX));
        send_ring_item(well_formed(CMD_ACQUIRE_TX));
        send_ring_item(ring_item(CMD_SUBMIT_TX, SEQ_BITS'(1), '0, '0, '0));
        send_ring_item(ring_item(CMD_SUBMIT_TX, '0, '1, '0, '0));
        send_ring_item(well_formed(CMD_SUBMIT_TX));
        send_ring_item(well_formed(CMD_QUIESCE));
        it = well_formed(CMD_TX_DONE);
        it.nframes = '0;
        send_ring_item(it);
        it.nframes    = '1;
        it.byte_count = '1;
        send_ring_item(it);
        send_ring_item(well_formed(CMD_TX_DONE));
        send_ring_item(well_formed(CMD_TX_DONE));
        it = well_formed(CMD_RX_EVENT);
        it.byte_count = it.byte_count - 1'b1;
        send_ring_item(it);
        it = well_formed(CMD_RX_EVENT);
        it.first = '1;
        send_ring_item(it);
        send_ring_item(well_formed(CMD_RX_CONSUMED));
        send_ring_item(ring_item(CMD_RX_CONSUMED, SEQ_BITS'(5), '0, '0, '0));
        send_ring_item(well_formed(CMD_RX_EVENT));
        send_ring_item(well_formed(CMD_RX_EVENT));
        send_ring_item(well_formed(CMD_RX_CONSUMED));
        send_ring_item(well_formed(CMD_SUBMIT_TX));
        send_ring_item(well_formed(CMD_TX_DONE));
        send_ring_item(well_formed(CMD_QUIESCE));
    endtask

    task automatic test_slot_retry();
        settle_pipeline();
        write_tracker_reg(CFG_SLOT_COUNT, CFG_DATA_W'(1));
        send_ring_item(well_formed(CMD_ACQUIRE_TX));
        send_ring_item(well_formed(CMD_ACQUIRE_TX));
        send_ring_item(well_formed(CMD_SUBMIT_TX));
        send_ring_item(well_formed(CMD_ACQUIRE_TX));
        send_ring_item(well_formed(CMD_TX_DONE));
        send_ring_item(well_formed(CMD_ACQUIRE_TX));
        send_ring_item(well_formed(CMD_SUBMIT_TX));
        send_ring_item(well_formed(CMD_TX_DONE));
        send_ring_item(well_formed(CMD_QUIESCE));
    endtask

    task automatic test_config_sweep();
        logic [CFG_DATA_W-1:0] slots_w;
        logic [CFG_DATA_W-1:0] bytes_w;
        for (int p = 0; p < 9; p++) begin
            case (p)
                0: begin slots_w = 17'd4096;  bytes_w = 17'd65536;  end
                1: begin slots_w = 17'h12003; bytes_w = 17'd1;      end
                2: begin slots_w = 17'd8191;  bytes_w = 17'd131071; end
                3: begin slots_w = 17'd0;     bytes_w = 17'd0;      end
                4: begin slots_w = 17'd1;     bytes_w = 17'd4096;   end
                5: begin slots_w = 17'd2;     bytes_w = CFG_DATA_W'($urandom); end
                6: begin slots_w = 17'd4095;  bytes_w = CFG_DATA_W'($urandom); end
                7: begin slots_w = 17'd5;     bytes_w = 17'd65535;  end
                default: begin slots_w = 17'd16; bytes_w = 17'd4096; end
            endcase
            settle_pipeline();
            write_tracker_reg(CFG_SLOT_COUNT, slots_w);
            write_tracker_reg(CFG_FRAME_BYTES, bytes_w);
            run_ring_traffic(200);
        end
    endtask

    task automatic test_peer_close();
        send_ring_item(well_formed(CMD_ACQUIRE_TX));
        send_ring_item(well_formed(CMD_CLOSE));
        send_ring_item(well_formed(CMD_QUIESCE));
        send_ring_item(well_formed(CMD_ACQUIRE_TX));
        send_ring_item(well_formed(CMD_SUBMIT_TX));
        repeat (3) send_ring_item(well_formed(CMD_RX_CONSUMED));
        send_ring_item(well_formed(CMD_RX_EVENT));
        send_ring_item(well_formed(CMD_CLOSE));
        run_ring_traffic(60);
        settle_pipeline();
        while (tx_done != tx_sub) send_ring_item(well_formed(CMD_TX_DONE));
        while (rx_arr < rx_con) send_ring_item(well_formed(CMD_RX_EVENT));
        send_ring_item(well_formed(CMD_QUIESCE));
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            if (mismatches < REPORT_MAX)
                $display("mismatch on %s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_status.size() == 0) begin
                if (mismatches < REPORT_MAX)
                    $display("result beat with nothing expected: status %0d", m_status);
                mismatches++;
            end else begin
                due = pending_status.pop_front();
                check_field("status", 64'(due.status), 64'(m_status));
                check_field("repost_frames", 64'(due.repost_frames), 64'(m_repost_frames));
                check_field("slot_first_frame", 64'(due.slot_first_frame),
                            64'(m_slot_first_frame));
                check_field("closed_flag", 64'(due.closed_flag), 64'(m_closed_flag));
                check_field("all_idle", 64'(due.all_idle), 64'(m_all_idle));
            end
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_cmd        = '0;
        s_seq        = '0;
        s_first      = '0;
        s_nframes    = '0;
        s_byte_count = '0;
        tx_acq       = '0;
        tx_sub       = '0;
        tx_done      = '0;
        rx_arr       = '0;
        rx_con       = '0;
        rx_rep       = '0;
        foreach (slot_ix[k]) slot_ix[k] = '0;
        link_gone    = 1'b0;
        reg_slots    = SLOT_COUNT_RST;
        reg_fbytes   = FRAME_BYTES_RST;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_basics();
        test_slot_retry();
        test_config_sweep();
        test_peer_close();
        settle_pipeline();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
